// ===== rtl/lkvc_pkg.sv =====
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types, widths and codes for the LRU key/value cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 5;
  localparam int CMP_W   = (CAP_W > OCC_W) ? CAP_W : OCC_W;
  localparam int KEY_W   = 64;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = 32;

  localparam int S_TDATA_W = ((KEY_W + VAL_W + 7) / 8) * 8;
  localparam int RES_W     = 1 + VAL_W + 1 + KEY_W + 3 * CNT_W;
  localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;
  localparam int M_PAD_W   = (M_TDATA_W > RES_W) ? (M_TDATA_W - RES_W) : 1;

  // APB register map
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 3;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_CAPACITY = 1'b0;
  localparam logic [CAP_W-1:0]     CAPACITY_RST = CAP_W'(16);

  typedef enum logic {
    KIND_GET = 1'b0,
    KIND_PUT = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } item_t;

  typedef struct packed {
    logic              hit;
    logic [VAL_W-1:0]  read_value;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
    logic [CNT_W-1:0]  lookup_count;
    logic [CNT_W-1:0]  miss_count;
    logic [CNT_W-1:0]  eviction_count;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/lkvc_cfg.sv =====
// ----------------------------------------------------------------------------
// lkvc_cfg
// APB register file holding the capacity register.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_cfg (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [lkvc_pkg::APB_AW-1:0] paddr,
  input  wire  [lkvc_pkg::APB_DW-1:0] pwdata,
  output logic [lkvc_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output logic [lkvc_pkg::CAP_W-1:0]  capacity
);
  import lkvc_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  // word addressing: low two address bits are ignored
  assign reg_idx = paddr[APB_AW-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RST;
    end else if (wr_en && (reg_idx == REG_CAPACITY)) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_CAPACITY) begin
      prdata = APB_DW'(capacity);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lkvc_core.sv =====
// ----------------------------------------------------------------------------
// lkvc_core
// Entry store with parallel key match, recency ranks and LRU replacement.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_core (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         go,
  input  wire  lkvc_pkg::item_t       item,
  input  wire  [lkvc_pkg::CAP_W-1:0]  capacity,
  output lkvc_pkg::result_t           res
);
  import lkvc_pkg::*;

  logic [ENTRIES-1:0]  valid;
  logic [KEY_W-1:0]    key   [ENTRIES];
  logic [VAL_W-1:0]    value [ENTRIES];
  logic [RANK_W-1:0]   rank  [ENTRIES];
  logic [OCC_W-1:0]    occ;
  logic [CNT_W-1:0]    lookups;
  logic [CNT_W-1:0]    misses;
  logic [CNT_W-1:0]    evictions;

  logic [ENTRIES-1:0]  valid_next;
  logic [RANK_W-1:0]   rank_next [ENTRIES];
  logic [OCC_W-1:0]    occ_next;
  logic [CNT_W-1:0]    lookups_next;
  logic [CNT_W-1:0]    misses_next;
  logic [CNT_W-1:0]    evictions_next;

  logic [ENTRIES-1:0]  hit_vec;
  logic [ENTRIES-1:0]  old_vec;
  logic [ENTRIES-1:0]  free_vec;
  logic [ENTRIES-1:0]  ins_vec;
  logic                hit;
  logic                is_put;
  logic                do_evict;
  logic                do_insert;
  logic                found;
  logic [RANK_W-1:0]   hit_rank;
  logic [VAL_W-1:0]    hit_value;
  logic [KEY_W-1:0]    old_key;
  logic [CMP_W-1:0]    cap_ext;
  logic [CMP_W-1:0]    eff_cap;
  logic [OCC_W-1:0]    occ_evicted;

  always_comb begin
    is_put = (item.kind == KIND_PUT);

    // associative match and lane reads (one-hot AND-OR)
    hit_rank  = '0;
    hit_value = '0;
    old_key   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid[i] && (key[i] == item.key);
      old_vec[i] = valid[i] && (rank[i] == '0);
      hit_rank   = hit_rank  | (hit_vec[i] ? rank[i]  : '0);
      hit_value  = hit_value | (hit_vec[i] ? value[i] : '0);
      old_key    = old_key   | (old_vec[i] ? key[i]   : '0);
    end
    hit = |hit_vec;

    // capacity clamped to 1..ENTRIES
    cap_ext = CMP_W'(capacity);
    eff_cap = cap_ext;
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end

    do_evict    = is_put && !hit && (CMP_W'(occ) >= eff_cap) && (occ != '0);
    do_insert   = is_put && !hit;
    occ_evicted = do_evict ? (occ - OCC_W'(1)) : occ;

    // lowest free slot after the eviction
    free_vec = ~valid | (do_evict ? old_vec : '0);
    ins_vec  = '0;
    found    = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (free_vec[i] && !found) begin
        ins_vec[i] = do_insert;
        found      = 1'b1;
      end
    end

    // rank and valid updates
    valid_next = valid;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_next[i] = rank[i];
      if (hit) begin
        if (hit_vec[i]) begin
          rank_next[i] = RANK_W'(occ - OCC_W'(1));
        end else if (valid[i] && (rank[i] > hit_rank)) begin
          rank_next[i] = rank[i] - RANK_W'(1);
        end
      end else if (do_evict && valid[i]) begin
        if (old_vec[i]) begin
          valid_next[i] = 1'b0;
        end else begin
          rank_next[i] = rank[i] - RANK_W'(1);
        end
      end
      if (ins_vec[i]) begin
        valid_next[i] = 1'b1;
        rank_next[i]  = RANK_W'(occ_evicted);
      end
    end
    occ_next = occ_evicted + OCC_W'(|ins_vec);

    lookups_next   = lookups   + CNT_W'(!is_put);
    misses_next    = misses    + CNT_W'(!is_put && !hit);
    evictions_next = evictions + CNT_W'(do_evict);

    res.hit            = hit;
    res.read_value     = (!is_put && hit) ? hit_value : '0;
    res.evicted        = do_evict;
    res.evicted_key    = do_evict ? old_key : '0;
    res.lookup_count   = lookups_next;
    res.miss_count     = misses_next;
    res.eviction_count = evictions_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      occ       <= '0;
      lookups   <= '0;
      misses    <= '0;
      evictions <= '0;
    end else if (go) begin
      valid     <= valid_next;
      occ       <= occ_next;
      lookups   <= lookups_next;
      misses    <= misses_next;
      evictions <= evictions_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= rank_next[i];
        if (ins_vec[i]) begin
          key[i] <= item.key;
        end
        if (ins_vec[i] || (is_put && hit_vec[i])) begin
          value[i] <= item.value;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lru_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  s_*       in    tvalid/tready    tuser: kind; tdata: key, value
//  m_*       out   tvalid/tready    tdata: hit .. eviction_count
//  apb       in    psel/penable     capacity at byte address 0
//
//  One transaction per cycle unless m_tready stalls: an accepted item is held in
//  the input register, is resolved against all entries in a single pass and
//  its result is registered onto m_tdata.
//  Reset clears valid marks, occupancy and counters; capacity returns to 16.
//  A stall on m_tready holds the result; the input register still takes one
//  more item until both stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            s_tvalid,
  output logic                           s_tready,
  input  wire                            s_tuser,   // [0] kind
  input  wire  [lkvc_pkg::S_TDATA_W-1:0] s_tdata,   // [63:0] key, [95:64] value
  output logic                           m_tvalid,
  input  wire                            m_tready,
  // [0] hit, [32:1] read_value, [33] evicted, [97:34] evicted_key,
  // [129:98] lookup_count, [161:130] miss_count, [193:162] eviction_count
  output logic [lkvc_pkg::M_TDATA_W-1:0] m_tdata,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [lkvc_pkg::APB_AW-1:0]    paddr,
  input  wire  [lkvc_pkg::APB_DW-1:0]    pwdata,
  output logic [lkvc_pkg::APB_DW-1:0]    prdata,
  output logic                           pready
);
  import lkvc_pkg::*;

  logic              in_valid;
  item_t             in_item;
  logic              advance;
  result_t           res;
  logic [CAP_W-1:0]  capacity;
  logic [M_PAD_W-1:0] pad;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign pad      = '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.kind  <= kind_t'(s_tuser);
      in_item.key   <= s_tdata[KEY_W-1:0];
      in_item.value <= s_tdata[KEY_W+VAL_W-1:KEY_W];
    end
  end

  lkvc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  lkvc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .go       (advance),
    .item     (in_item),
    .capacity (capacity),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= M_TDATA_W'({pad, res.eviction_count, res.miss_count, res.lookup_count,
                             res.evicted_key, res.evicted, res.read_value, res.hit});
    end
  end

endmodule

`default_nettype wire
